### src/simpson_mean_square_spl_meter_top_assert.svh
// assertion macros for the spl meter
`ifndef SIMPSON_MEAN_SQUARE_SPL_METER_TOP_ASSERT_SVH
`define SIMPSON_MEAN_SQUARE_SPL_METER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spl check failed");
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spl check failed");
`else
`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/smsspl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smsspl_pkg;
  localparam int unsigned NCH = 8;
  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned MAX_FRAMES_DEF = 65536;
  localparam int unsigned SUM_W = 50;
  localparam int unsigned CNT_W = 17;
  localparam logic [31:0] GAIN_RESET = 32'd65536;
  localparam logic signed [63:0] DB_PER_LOG2_Q16 = 64'sd197283;
  localparam logic signed [63:0] LEVEL_OFFSET_Q24 = 64'sd247979316;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EVEN = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  // simpson weight selects
  localparam logic [1:0] WSEL_1 = 2'd0;
  localparam logic [1:0] WSEL_2 = 2'd1;
  localparam logic [1:0] WSEL_4 = 2'd2;
  // log operand phases
  localparam logic [1:0] LS_GAIN = 2'd0;
  localparam logic [1:0] LS_SUM = 2'd1;
  localparam logic [1:0] LS_INTV = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_LOGS, S_LOGW, S_SUM, S_MUL, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] q24;
  } log_rsp_t;
endpackage
`default_nettype wire

### src/smsspl_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// shared iterative log2 in q.24: normalize, then one squaring per fraction bit
module smsspl_log2
  import smsspl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire log_req_t req,
  output log_rsp_t      rsp
);
  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_DONE} lstate_t;
  lstate_t     st_r, st_nxt;
  logic [63:0] x_r, x_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [32:0] m_r, m_nxt;
  logic [23:0] f_r, f_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [65:0] sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r <= x_nxt; e_r <= e_nxt; m_r <= m_nxt; f_r <= f_nxt; i_r <= i_nxt;
  end

  assign sq = {33'd0, m_r} * {33'd0, m_r};

  // normalize by 8 bits a step, then 1 bit a step
  always_comb begin
    st_nxt = st_r; x_nxt = x_r; e_nxt = e_r; m_nxt = m_r; f_nxt = f_r; i_nxt = i_r;
    case (st_r)
      L_IDLE: begin
        if (req.start) begin
          x_nxt = req.x; e_nxt = 6'd63; f_nxt = '0; i_nxt = 5'd23; st_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (e_r == 6'd0 || x_r[63]) begin
          // x_r holds x << (63-e); mantissa q1.31 is the top 32 bits
          m_nxt = {1'b0, x_r[63:32]};
          st_nxt = L_SQ;
        end else if (x_r[63:56] == 8'd0 && e_r >= 6'd8) begin
          x_nxt = x_r << 8; e_nxt = e_r - 6'd8;
        end else begin
          x_nxt = x_r << 1; e_nxt = e_r - 6'd1;
        end
      end
      L_SQ: begin
        if (sq[63]) begin
          f_nxt[i_r] = 1'b1;
          m_nxt = {1'b0, sq[63:32]};
        end else begin
          m_nxt = sq[63:31];
        end
        if (i_r == 5'd0) st_nxt = L_DONE;
        else i_nxt = i_r - 5'd1;
      end
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  assign rsp.done = (st_r == L_DONE);
  assign rsp.q24 = {1'b0, e_r, f_r};
endmodule
`default_nettype wire

### src/smsspl_top_dummy_guard.sv
`timescale 1ns / 1ps
`default_nettype none
// weighted squarer: one channel per cycle, square times simpson weight
module smsspl_sqacc
  import smsspl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [15:0] smp,
  input  wire logic [1:0]         wsel,
  input  wire logic [SUM_W-1:0]   acc,
  output logic [SUM_W-1:0]        acc_new
);
  logic [31:0] sq_r;
  logic [1:0]  w_r;
  logic [SUM_W-1:0] wsq;
  always_ff @(posedge clk) begin
    sq_r <= 32'(smp * smp);
    w_r  <= wsel;
  end
  // weight 2 and 4 as shifts, weight 1 otherwise
  always_comb begin
    case (w_r)
      WSEL_2:  wsq = {{(SUM_W-33){1'b0}}, sq_r, 1'b0};
      WSEL_4:  wsq = {{(SUM_W-34){1'b0}}, sq_r, 2'b0};
      default: wsq = {{(SUM_W-32){1'b0}}, sq_r};
    endcase
  end
  assign acc_new = acc + wsq;
endmodule
`default_nettype wire

### src/simpson_mean_square_spl_meter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Eight-channel Simpson mean-square sound level meter. Each input beat is one frame
// (sample_ch0..7 in in_tdata from bit 0 up, final_frame in in_tlast); one shared squarer
// visits the channels in turn, so a frame keeps the input not ready until it has visited
// them all. On the final frame one result beat per channel follows (channel, level_db,
// status in out_tdata, last_channel in out_tlast): each level runs three log2 evaluations
// on one shared unit, whose run time depends on the leading zeros of the operand, plus a
// multiply; short records, zero gains and zero sums skip the logs. A result beat held off
// by the receiver stalls the sequencer, and the input stays not ready until the last
// result beat has left. Gains are written at cfg indexes 0..7 while the block is idle.
module simpson_mean_square_spl_meter_top
  import smsspl_pkg::*;
#(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // sample_ch0..sample_ch7, 16 bits each
  input  wire logic         in_tlast,   // final_frame
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // channel[2:0], level_db[18:3], status[20:19]
  output logic              out_tlast   // last_channel
);
`include "simpson_mean_square_spl_meter_top_assert.svh"
  logic [31:0]      gain_r [NCH];
  logic [SUM_W-1:0] sum_r [NCH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  state_t           st_r, st_nxt;
  logic [127:0]     smp_r, smp_nxt;
  logic             fin_r, fin_nxt;
  logic [3:0]       ch_r, ch_nxt;
  logic [1:0]       wsel_r, wsel_nxt;
  logic [1:0]       ls_r, ls_nxt;
  logic signed [32:0] l2_r, l2_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      lvl_r, lvl_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [23:0]      odata_r, odata_nxt;
  logic             olast_r, olast_nxt;
  logic [SUM_W-1:0] acc_new;
  logic [CNT_W:0]   n_ext;
  log_req_t         lreq;
  log_rsp_t         lrsp;
  logic [63:0]      lx;
  logic [2:0]       ch3;
  logic [2:0]       chp;
  logic signed [63:0] q;
  logic             chv;

  assign ch3 = ch_r[2:0];
  // channel whose square leaves the squarer's register stage this cycle
  assign chp = 3'(ch_r - 4'd1);
  assign chv = (32'(ch_r) < CHANNELS);
  assign n_ext = {1'b0, cnt_r} + 1'b1;

  smsspl_sqacc u_sq (
    .clk(clk), .smp(smp_r[16*ch3 +: 16]), .wsel(wsel_r), .acc(sum_r[chp]), .acc_new(acc_new)
  );
  smsspl_log2 u_log (.clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp));

  // log operand per phase: gain, sum, 3*(n-1)
  always_comb begin
    case (ls_r)
      LS_GAIN: lx = {32'd0, gain_r[ch3]};
      LS_SUM:  lx = {{(64-SUM_W){1'b0}}, sum_r[ch3]};
      default: lx = 64'({cnt_r, 1'b0}) + 64'(cnt_r);
    endcase
  end

  assign cfg_ready = (st_r == S_IDLE);
  assign in_tready = (st_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
  assign q = (prod_r + 64'sd2147483648) >>> 32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ovalid_r <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        gain_r[i] <= GAIN_RESET; sum_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready && cfg_index < 32'd8) gain_r[cfg_index[2:0]] <= cfg_data;
      if (st_r == S_ACC && ch_r != 4'd0 && 32'(ch_r) <= CHANNELS)
        sum_r[chp] <= acc_new;
      if (st_r == S_FIN && ch_r == 4'd8)
        for (int i = 0; i < NCH; i++) sum_r[i] <= '0;
    end
    smp_r <= smp_nxt; fin_r <= fin_nxt; ch_r <= ch_nxt; wsel_r <= wsel_nxt;
    ls_r <= ls_nxt; l2_r <= l2_nxt; status_r <= status_nxt; lvl_r <= lvl_nxt;
    prod_r <= prod_nxt; odata_r <= odata_nxt; olast_r <= olast_nxt;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; smp_nxt = smp_r; fin_nxt = fin_r; ch_nxt = ch_r;
    wsel_nxt = wsel_r; ls_nxt = ls_r; l2_nxt = l2_r; status_nxt = status_r;
    lvl_nxt = lvl_r; prod_nxt = prod_r; ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    olast_nxt = olast_r;
    lreq.start = 1'b0; lreq.x = lx;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (!in_tlast && 32'(cnt_r) >= MAX_FRAMES - 1) begin
            st_nxt = S_IDLE;
          end else begin
            smp_nxt = in_tdata; fin_nxt = in_tlast; ch_nxt = 4'd0; st_nxt = S_ACC;
            // ch_r sits one ahead of the squarer's register stage
            if (cnt_r == '0 || in_tlast) wsel_nxt = WSEL_1;
            else if (cnt_r[0]) wsel_nxt = WSEL_4;
            else wsel_nxt = WSEL_2;
          end
        end
      end
      S_ACC: begin
        if (ch_r == 4'(NCH)) begin
          if (!fin_r) begin
            cnt_nxt = cnt_r + 1'b1; st_nxt = S_IDLE;
          end else begin
            ch_nxt = 4'd0; st_nxt = S_LOGS;
            if (n_ext < 3) status_nxt = ST_SHORT;
            else if (!n_ext[0]) status_nxt = ST_EVEN;
            else status_nxt = ST_OK;
          end
        end else begin
          ch_nxt = ch_r + 4'd1;
        end
      end
      S_LOGS: begin
        ls_nxt = LS_GAIN; l2_nxt = '0;
        // first log of a channel always takes the gain
        lreq.x = {32'd0, gain_r[ch3]};
        if (!chv) begin
          ch_nxt = 4'd8; st_nxt = S_FIN;
        end else if (status_r == ST_SHORT || gain_r[ch3] == '0 || sum_r[ch3] == '0) begin
          lvl_nxt = 16'h8000; st_nxt = S_OUT;
        end else begin
          lreq.start = 1'b1; st_nxt = S_LOGW;
        end
      end
      S_LOGW: begin
        if (lrsp.done) begin
          if (ls_r == LS_INTV) begin
            l2_nxt = l2_r - 33'(lrsp.q24); st_nxt = S_MUL;
          end else begin
            l2_nxt = l2_r + 33'(lrsp.q24); ls_nxt = ls_r + 2'd1; st_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        lreq.start = 1'b1; st_nxt = S_LOGW;
      end
      S_MUL: begin
        prod_nxt = (64'(l2_r) - LEVEL_OFFSET_Q24) * DB_PER_LOG2_Q16;
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (ch_r == 4'd8) begin
          cnt_nxt = '0; st_nxt = S_IDLE;
        end else begin
          if (q < -64'sd32768) lvl_nxt = 16'h8000;
          else if (q > 64'sd32767) lvl_nxt = 16'h7fff;
          else lvl_nxt = q[15:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt = {3'b0, status_r, lvl_r, ch3};
          olast_nxt = (32'(ch_r) == CHANNELS - 1);
          if (32'(ch_r) == CHANNELS - 1) begin
            ch_nxt = 4'd8; st_nxt = S_FIN;
          end else begin
            ch_nxt = ch_r + 4'd1; st_nxt = S_LOGS;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  `SPL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SPL_ASSERT_IMPL(a_busy, clk, rst_n, st_r != S_IDLE, !in_tready)
  `SPL_ASSERT_IMPL(a_short_min, clk, rst_n, out_tvalid && out_tdata[20:19] == ST_SHORT, out_tdata[18:3] == 16'h8000)
endmodule
`default_nettype wire
